@@ rtl/sme_pkg.sv @@
// Shared types and constants for the stack machine executor.
package sme_pkg;
	localparam int unsigned StackDepth = 64;
	localparam int unsigned PtrW = $clog2(StackDepth);
	localparam int unsigned CntW = $clog2(StackDepth + 1);
	localparam int unsigned DivSteps = 128;
	localparam int unsigned StepW = $clog2(DivSteps);

	typedef enum logic [3:0] {
		OP_PUSH = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3,
		OP_DIV = 4'd4, OP_POP = 4'd5, OP_IN = 4'd6, OP_OUT = 4'd7, OP_HALT = 4'd8
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_UNDER = 2'd1, ST_OVER = 2'd2, ST_DIVZ = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_READ_T, S_READ_N, S_EXEC, S_MUL, S_DIV, S_WRITE, S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;      // capture the instruction
		logic       rd_top;    // read entry depth-1
		logic       rd_next;   // read entry depth-2
		logic       cap_t;     // capture read data as t
		logic       cap_n;     // capture read data as n
		logic       mul_go;    // multiply partial-product step
		logic       div_start;
		logic       div_step;
		logic       wr_push;   // write pushed value, depth+1
		logic       wr_arith;  // write result at depth-2, depth-1
		logic       pop;       // depth-1
		logic       set_out;   // latch t as output value
		logic [1:0] err;       // status_t of this instruction
		logic       fin;       // result register load
		logic       res_take;  // result transferred
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		opcode_t   op;
		logic      has1;
		logic      has2;
		logic      full;
		logic      n_zero;
		logic      div_last;
		logic      mul_last;
	} dp_stat_t;
endpackage

@@ rtl/sme_ctrl.sv @@
// Controller state machine for the stack machine executor.
module sme_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             out_stall,
	output logic             res_valid,
	input  sme_pkg::dp_stat_t st,
	output sme_pkg::dp_cmd_t  cmd
);
	import sme_pkg::*;

	state_t state_q, state_d;
	logic   rvalid_q;

	assign res_valid = rvalid_q;
	assign in_stall  = (state_q != S_IDLE) || (rvalid_q && out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid && !in_stall) state_d = S_READ_T;
			S_READ_T: state_d = S_READ_N;
			S_READ_N: state_d = S_EXEC;
			S_EXEC: begin
				if ((st.op == OP_MUL) && st.has2) state_d = S_MUL;
				else if ((st.op == OP_DIV) && st.has2 && !st.n_zero) state_d = S_DIV;
				else if ((st.op == OP_ADD || st.op == OP_SUB) && st.has2) state_d = S_WRITE;
				else state_d = S_DONE;
			end
			S_MUL:    if (st.mul_last) state_d = S_WRITE;
			S_DIV:    if (st.div_last) state_d = S_WRITE;
			S_WRITE:  state_d = S_DONE;
			S_DONE:   if (!rvalid_q || !out_stall) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.res_take = rvalid_q && !out_stall;
		unique case (state_q)
			S_IDLE:   cmd.load = in_valid && !in_stall;
			S_READ_T: cmd.rd_top = 1'b1;
			S_READ_N: begin
				cmd.rd_next = 1'b1;
				cmd.cap_t = 1'b1;
			end
			S_EXEC: begin
				cmd.cap_n = 1'b1;
				unique case (st.op)
					OP_PUSH, OP_IN: begin
						if (st.full) cmd.err = ST_OVER;
						else cmd.wr_push = 1'b1;
					end
					OP_ADD, OP_SUB: begin
						if (!st.has2) cmd.err = ST_UNDER;
					end
					OP_MUL: begin
						if (!st.has2) cmd.err = ST_UNDER;
					end
					OP_DIV: begin
						if (!st.has2) cmd.err = ST_UNDER;
						else if (st.n_zero) cmd.err = ST_DIVZ;
						else cmd.div_start = 1'b1;
					end
					OP_POP, OP_OUT: begin
						if (!st.has1) cmd.err = ST_UNDER;
						else begin
							cmd.pop = 1'b1;
							cmd.set_out = (st.op == OP_OUT);
						end
					end
					default: ;
				endcase
			end
			S_MUL:    cmd.mul_go = 1'b1;
			S_DIV:    cmd.div_step = 1'b1;
			S_WRITE:  cmd.wr_arith = 1'b1;
			S_DONE:   cmd.fin = !rvalid_q || !out_stall;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin) rvalid_q <= 1'b1;
			else if (cmd.res_take) rvalid_q <= 1'b0;
		end
	end
endmodule

@@ rtl/sme_datapath.sv @@
// Datapath: stack memory, depth counter, ALU, multiplier and divider.
module sme_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         func,
	input  logic signed [63:0] immediate,
	input  logic signed [63:0] in_value,
	input  sme_pkg::dp_cmd_t   cmd,
	output sme_pkg::dp_stat_t  st,
	output logic signed [63:0] out_value,
	output logic               out_valid,
	output logic [1:0]         status,
	output logic               halted
);
	import sme_pkg::*;

	localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;

	logic [63:0]     mem [StackDepth];
	logic [63:0]     rd_q;
	logic [CntW-1:0] depth_q;
	logic [3:0]      op_q;
	logic [63:0]     push_q, t_q, n_q, res_q, ov_q;
	logic [1:0]      err_q;
	logic            ovalid_q;
	logic [63:0]     ov_r;
	logic            vr_q;
	logic [1:0]      st_r;
	logic            h_r;
	// mul/div registers; neg_q and mb_q are shared
	logic            neg_q;
	logic [63:0]     ma_q, mb_q;
	logic [2:0]      mstep_q;
	logic [2:0]      mprev;
	logic [1:0]      msh;
	logic [127:0]    prod_q;
	logic [63:0]     pp_q;
	logic [StepW-1:0] dstep_q;
	logic [127:0]    num_q;
	logic [64:0]     rem_q;
	logic [63:0]     quo_q;
	logic            dovf_q;

	logic [CntW-1:0] dm1, dm2;
	logic [PtrW-1:0] rd_addr, wr_addr;
	logic [63:0]     wr_data;
	logic            wr_en;
	logic [63:0]     sum, dif, alu;

	assign dm1 = depth_q - CntW'(1);
	assign dm2 = depth_q - CntW'(2);

	assign st.op       = opcode_t'(op_q);
	assign st.has1     = depth_q >= CntW'(1);
	assign st.has2     = depth_q >= CntW'(2);
	assign st.full     = depth_q >= CntW'(StackDepth);
	assign st.n_zero   = (rd_q == '0);
	assign st.div_last = (dstep_q == StepW'(DivSteps - 1));
	assign st.mul_last = (mstep_q == 3'd5);

	function automatic logic [63:0] mag(input logic [63:0] v);
		mag = v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [63:0] ssat(input logic neg, input logic [63:0] m,
		input logic ovf);
		if (!neg) ssat = (ovf || m > MaxPos) ? MaxPos : m;
		else if (ovf || m > MinNeg) ssat = MinNeg;
		else ssat = 64'd0 - m;
	endfunction

	assign sum = t_q + n_q;
	assign dif = t_q - n_q;
	always_comb begin
		if (op_q == OP_ADD) begin
			alu = sum;
			if (!(t_q[63] ^ n_q[63]) && (t_q[63] ^ sum[63])) alu = t_q[63] ? MinNeg : MaxPos;
		end else begin
			alu = dif;
			if ((t_q[63] ^ n_q[63]) && (t_q[63] ^ dif[63])) alu = t_q[63] ? MinNeg : MaxPos;
		end
	end

	assign rd_addr = cmd.rd_top ? dm1[PtrW-1:0] : dm2[PtrW-1:0];
	assign wr_en   = cmd.wr_push || cmd.wr_arith;
	assign wr_addr = cmd.wr_push ? depth_q[PtrW-1:0] : dm2[PtrW-1:0];
	always_comb begin
		if (cmd.wr_push) wr_data = push_q;
		else if (op_q == OP_ADD || op_q == OP_SUB) wr_data = alu;
		else if (op_q == OP_DIV) wr_data = ssat(neg_q, quo_q, dovf_q);
		else wr_data = res_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) depth_q <= '0;
		else if (cmd.wr_push) depth_q <= depth_q + CntW'(1);
		else if (cmd.wr_arith || cmd.pop) depth_q <= dm1;
	end

	// 32x32 partial products, one per cycle, registered before accumulation;
	// step 0..3 forms a product, step 1..4 adds the previous one, step 5 saturates
	logic [31:0] pa, pb;
	always_comb begin
		pa = mstep_q[0] ? ma_q[63:32] : ma_q[31:0];
		pb = mstep_q[1] ? mb_q[63:32] : mb_q[31:0];
	end
	assign mprev = mstep_q - 3'd1;
	assign msh   = {1'b0, mprev[1]} + {1'b0, mprev[0]};

	logic [64:0] trial;
	logic [127:0] nsh;
	assign nsh   = num_q;
	assign trial = {rem_q[63:0], nsh[127]} - {1'b0, mb_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= func;
			push_q <= (func == OP_PUSH) ? immediate : in_value;
		end
		if (cmd.cap_t) t_q <= rd_q;
		if (cmd.cap_n) begin
			n_q     <= rd_q;
			neg_q   <= t_q[63] ^ rd_q[63];
			ma_q    <= mag(t_q);
			mb_q    <= mag(rd_q);
			mstep_q <= '0;
			prod_q  <= '0;
		end
		if (cmd.div_start) begin
			dstep_q <= '0;
			num_q   <= {32'd0, mag(t_q), 32'd0};
			rem_q   <= '0;
			quo_q   <= '0;
			dovf_q  <= 1'b0;
		end
		if (cmd.mul_go) begin
			mstep_q <= mstep_q + 3'd1;
			if (mstep_q < 3'd4) pp_q <= pa * pb;
			if ((mstep_q != 3'd0) && (mstep_q < 3'd5))
				prod_q <= prod_q + ({64'd0, pp_q} << {msh, 5'd0});
			if (st.mul_last)
				res_q <= ssat(neg_q, prod_q[95:32], prod_q[127:96] != '0);
		end
		if (cmd.div_step) begin
			num_q   <= {num_q[126:0], 1'b0};
			dstep_q <= dstep_q + StepW'(1);
			if (quo_q[63]) dovf_q <= 1'b1;
			if (!trial[64]) begin
				rem_q <= trial;
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[63:0], num_q[127]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
		if (cmd.set_out) ov_q <= t_q;
		if (cmd.load) begin
			ovalid_q <= 1'b0;
			err_q    <= ST_OK;
		end
		if (cmd.cap_n) err_q <= cmd.err;
		if (cmd.set_out) ovalid_q <= 1'b1;
		if (cmd.fin) begin
			ov_r <= ovalid_q ? ov_q : 64'd0;
			vr_q <= ovalid_q;
			st_r <= err_q;
			h_r  <= (op_q == OP_HALT);
		end
	end

	assign out_value = ov_r;
	assign out_valid = vr_q;
	assign status    = st_r;
	assign halted    = h_r;
endmodule

@@ rtl/stack_machine_executor.sv @@
// Top level of the stack machine executor.
//
//  channel | signals                               | direction
//  input   | in_valid, in_stall, func, immediate,  | item in
//          | in_value                              |
//  output  | res_valid, out_stall, out_value,      | result out
//          | out_valid, status, halted             |
//
// One instruction at a time. Each passes S_READ_T, S_READ_N and S_EXEC; a
// valid add, sub, mul or div then writes in S_WRITE, mul after four 32x32
// partial products through one multiplier and a saturate, div after one quotient
// bit per cycle over 128 bits. The single read port fetches operands in turn.
// Reset empties the stack at once; no clearing pass.
// A stalled result holds; the next transfer is taken once it is gone.
module stack_machine_executor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         func,
	input  logic signed [63:0] immediate,
	input  logic signed [63:0] in_value,
	output logic               res_valid,
	input  logic               out_stall,
	output logic signed [63:0] out_value,
	output logic               out_valid,
	output logic [1:0]         status,
	output logic               halted
);
	import sme_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t st;

	// sequence each instruction
	sme_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_stall, .res_valid, .st, .cmd
	);

	// hold the stack and do the arithmetic
	sme_datapath u_dp (
		.clk, .arst_n, .func, .immediate, .in_value, .cmd, .st,
		.out_value, .out_valid, .status, .halted
	);
endmodule

@@ rtl/sme_checker.sv @@
// Port-level checks for the stack machine executor.
module sme_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       res_valid,
	input logic       out_stall,
	input logic       out_valid,
	input logic [1:0] status,
	input logic       halted
);
	import sme_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_stall |=> res_valid) else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("second transfer");
	a_ov: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_valid |-> status == ST_OK && !halted)
		else $error("out with error");
	a_h: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && halted |-> status == ST_OK) else $error("halt status");
endmodule

bind stack_machine_executor sme_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .res_valid, .out_stall,
	.out_valid, .status, .halted
);

@@ dv/tb_stack_machine_executor.sv @@
// Testbench for the stack machine executor: directed and random instructions, scoreboard check.
module tb_stack_machine_executor;
	timeunit 1ns;
	timeprecision 1ps;
	import sme_pkg::*;

	localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;
	localparam int unsigned RandItems = 800;
	localparam int unsigned CycleLimit = 1_000_000;
	localparam int unsigned LongHold = 300;
	localparam int unsigned DrainCycles = 150;

	typedef struct {
		logic [63:0] value;
		logic        valid;
		status_t     st;
		logic        halt;
	} exec_result_t;

	// Scoreboard: keeps its own copy of the stack and the queue of expected results.
	class ExecScoreboard;
		logic [63:0]  stack_mem [StackDepth];
		int unsigned  depth;
		exec_result_t expected_q [$];
		int           errors;
		int           mismatches;

		function new();
			depth = 0;
			errors = 0;
			mismatches = 0;
		endfunction

		function logic [63:0] magnitude(logic [63:0] v);
			return v[63] ? -v : v;
		endfunction

		function logic [63:0] saturate(bit neg, logic [63:0] mag, bit ovf);
			if (!neg)
				return (ovf || mag > MaxPos) ? MaxPos : mag;
			if (ovf || mag > MinNeg)
				return MinNeg;
			return -mag;
		endfunction

		function logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
			logic [63:0] s;
			s = a + b;
			if (a[63] == b[63] && s[63] != a[63])
				return a[63] ? MinNeg : MaxPos;
			return s;
		endfunction

		function logic [63:0] sub_sat(logic [63:0] a, logic [63:0] b);
			logic [63:0] d;
			d = a - b;
			if (a[63] != b[63] && d[63] != a[63])
				return a[63] ? MinNeg : MaxPos;
			return d;
		endfunction

		// Q32.32 product, truncated toward zero, then saturated.
		function logic [63:0] fx_product(logic [63:0] a, logic [63:0] b);
			logic [127:0] p;
			logic [95:0]  q;
			p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
			q = p[127:32];
			return saturate(a[63] ^ b[63], q[63:0], q[95:64] != 0);
		endfunction

		// Q32.32 quotient a / b, b nonzero.
		function logic [63:0] fx_quotient(logic [63:0] a, logic [63:0] b);
			logic [127:0] num;
			logic [127:0] q;
			num = {64'd0, magnitude(a)} << 32;
			q = num / {64'd0, magnitude(b)};
			return saturate(a[63] ^ b[63], q[63:0], q[127:64] != 0);
		endfunction

		function void note_instr(logic [3:0] f, logic [63:0] imm, logic [63:0] inv);
			exec_result_t r;
			logic [63:0] t, n;
			r = '{value: 64'd0, valid: 1'b0, st: ST_OK, halt: 1'b0};
			case (f)
				OP_PUSH, OP_IN: begin
					if (depth >= StackDepth)
						r.st = ST_OVER;
					else begin
						stack_mem[depth] = (f == OP_PUSH) ? imm : inv;
						depth++;
					end
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
					if (depth < 2)
						r.st = ST_UNDER;
					else begin
						t = stack_mem[depth-1];
						n = stack_mem[depth-2];
						if (f == OP_DIV && n == 0)
							r.st = ST_DIVZ;
						else begin
							case (f)
								OP_ADD: stack_mem[depth-2] = add_sat(t, n);
								OP_SUB: stack_mem[depth-2] = sub_sat(t, n);
								OP_MUL: stack_mem[depth-2] = fx_product(t, n);
								default: stack_mem[depth-2] = fx_quotient(t, n);
							endcase
							depth--;
						end
					end
				end
				OP_POP, OP_OUT: begin
					if (depth == 0)
						r.st = ST_UNDER;
					else begin
						depth--;
						if (f == OP_OUT) begin
							r.value = stack_mem[depth];
							r.valid = 1'b1;
						end
					end
				end
				OP_HALT: r.halt = 1'b1;
				default: ;
			endcase
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [63:0] v, logic vld, logic [1:0] st, logic hlt);
			exec_result_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("%0t: result with nothing expected", $realtime);
				return;
			end
			e = expected_q.pop_front();
			if (v !== e.value || vld !== e.valid || st !== e.st || hlt !== e.halt) begin
				errors++;
				if (mismatches++ < 10)
					$display("%0t: expected value=%h valid=%b status=%0d halted=%b, got %h %b %0d %b",
						$realtime, e.value, e.valid, e.st, e.halt, v, vld, st, hlt);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [3:0]         func = 4'd0;
	logic signed [63:0] immediate = '0;
	logic signed [63:0] in_value = '0;
	logic               res_valid;
	logic               out_stall = 1'b0;
	logic signed [63:0] out_value;
	logic               out_valid;
	logic [1:0]         status;
	logic               halted;

	ExecScoreboard sb = new();
	bit          idle_on = 1'b1;   // random bubbles on both channels
	bit          hold_req = 1'b0;  // ask the receiver for one long hold-off
	int unsigned cycles = 0;

	stack_machine_executor dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .immediate(immediate), .in_value(in_value),
		.res_valid(res_valid), .out_stall(out_stall),
		.out_value(out_value), .out_valid(out_valid), .status(status), .halted(halted)
	);

	always #2 clk = ~clk;

	// Watchdog: end the run if the block stops making progress.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("tb_stack_machine_executor: done, errors");
			$finish;
		end
	end

	// Result side: check every transfer, then pick the stall for the next cycle.
	// A long hold-off lets the block sit on a result so the input side backs up.
	initial begin : result_side
		int unsigned hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !out_stall)
				sb.check_result(out_value, out_valid, status, halted);
			if (hold_req) begin
				hold_req = 1'b0;
				hold = LongHold;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	// Offer one instruction and hold it until the block takes it.
	task automatic send_instr(logic [3:0] f, logic [63:0] imm, logic [63:0] inv);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		immediate <= imm;
		in_value <= inv;
		do @(posedge clk); while (in_stall);
		sb.note_instr(f, imm, inv);
	endtask

	// Mix of corner values, small Q32.32 numbers and raw random words.
	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return MaxPos;
			2: return MinNeg;
			3: return {$urandom, $urandom};
			4: return {$urandom, $urandom};
			5: return 64'(signed'($urandom_range(0, 20)) - 10) <<< 32;
			6: return {{32{1'b0}}, $urandom};
			7: return 64'(signed'($urandom_range(0, 200000)) - 100000) <<< 16;
			8: return -64'd1;
			default: return 64'd1;
		endcase
	endfunction

	function automatic logic [3:0] pick_op();
		int unsigned w;
		w = $urandom_range(0, 99);
		if (w < 18) return OP_PUSH;
		if (w < 30) return OP_IN;
		if (w < 40) return OP_ADD;
		if (w < 50) return OP_SUB;
		if (w < 60) return OP_MUL;
		if (w < 68) return OP_DIV;
		if (w < 76) return OP_POP;
		if (w < 90) return OP_OUT;
		if (w < 95) return OP_HALT;
		return 4'($urandom_range(9, 15));
	endfunction

	initial begin : stimulus
		int unsigned k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: underflow on an empty stack, saturation, divide by zero, halt, unused codes.
		send_instr(OP_ADD, '0, '0);
		send_instr(OP_DIV, '0, '0);
		send_instr(OP_POP, '0, '0);
		send_instr(OP_OUT, '0, '0);
		send_instr(OP_PUSH, MaxPos, '0);
		send_instr(OP_SUB, '0, '0);
		send_instr(OP_IN, '0, MaxPos);
		send_instr(OP_ADD, '0, '0);
		send_instr(OP_OUT, '0, '0);
		send_instr(OP_PUSH, MinNeg, '0);
		send_instr(OP_PUSH, MinNeg, '0);
		send_instr(OP_MUL, '0, '0);
		send_instr(OP_IN, '0, 64'd0);
		send_instr(OP_PUSH, 64'sd5 <<< 32, '0);
		send_instr(OP_DIV, '0, '0);
		send_instr(OP_POP, '0, '0);
		send_instr(OP_PUSH, 64'd1, '0);
		send_instr(OP_DIV, '0, '0);
		send_instr(OP_PUSH, -(64'sd3 <<< 31), '0);
		send_instr(OP_SUB, '0, '0);
		send_instr(OP_HALT, '0, '0);
		send_instr(4'd9, '0, '0);
		send_instr(4'd15, {64{1'b1}}, {64{1'b1}});
		send_instr(OP_OUT, '0, '0);
		send_instr(OP_OUT, '0, '0);

		// Random part; now and then fill the stack past the top, then drain it.
		for (k = 0; k < RandItems; k++) begin
			if (k == RandItems - 150)
				idle_on = 1'b0;
			if (k == 400)
				hold_req = 1'b1;
			if (k % 300 == 150) begin
				repeat (StackDepth + 3)
					send_instr($urandom_range(0, 1) ? OP_PUSH : OP_IN, pick_value(), pick_value());
				repeat (20)
					send_instr(pick_op(), pick_value(), pick_value());
				repeat (StackDepth)
					send_instr($urandom_range(0, 1) ? OP_POP : OP_OUT, '0, '0);
			end else
				send_instr(pick_op(), pick_value(), pick_value());
		end
		in_valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_stack_machine_executor: done, clean");
		else
			$display("tb_stack_machine_executor: done, errors");
		$finish;
	end
endmodule
